// File: src/sky_pixel_compositor_core_macros.svh
// assertion macros shared by the sky compositor rtl
`ifndef SKY_PIXEL_COMPOSITOR_CORE_MACROS_SVH
`define SKY_PIXEL_COMPOSITOR_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/spc_pkg.sv
// types, constants and constant tables of the sky pixel compositor
`timescale 1ns / 1ps

package spc_pkg;

    // panel geometry and sun size
    localparam int PANEL_WIDTH     = 64;
    localparam int ZONE_TOP        = 7;
    localparam int ZONE_BOTTOM     = 31;
    localparam int SUN_RADIUS      = 12;
    localparam int SUN_GLOW_RADIUS = 20;

    localparam int X_W       = 6;
    localparam int Y_W       = 5;
    localparam int CH_W      = 8;
    localparam int SPLIT_W   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 24;

    // three channels, index 2 is red (bits 23..16), 0 is blue
    typedef logic [2:0][CH_W-1:0] t_pix;
    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_BG_MODE        = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_BG_TOP_COLOR   = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_BG_BOTTOM_COLOR = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_SPLIT_ROW      = t_cfg_idx'(3);
    localparam t_cfg_idx CFG_SUN_COLOR      = t_cfg_idx'(4);
    localparam t_cfg_idx CFG_SUN_SKY_COLOR  = t_cfg_idx'(5);
    localparam t_cfg_idx CFG_MOON_SKY_COLOR = t_cfg_idx'(6);
    localparam t_cfg_idx CFG_LAYER_ENABLE   = t_cfg_idx'(7);

    localparam logic [1:0] MODE_BLACK   = 2'd0;
    localparam logic [1:0] MODE_SOLID   = 2'd1;
    localparam logic [1:0] MODE_SUNRISE = 2'd2;
    localparam logic [1:0] MODE_SUNSET  = 2'd3;

    localparam int LAYER_SUN  = 0;
    localparam int LAYER_MOON = 1;

    typedef struct packed {
        logic [1:0]         bg_mode;
        t_pix               bg_top_color;
        t_pix               bg_bottom_color;
        logic [SPLIT_W-1:0] split_row;
        t_pix               sun_color;
        t_pix               sun_sky_color;
        t_pix               moon_sky_color;
        logic [1:0]         layer_enable;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        bg_mode:         MODE_SOLID,
        bg_top_color:    24'h000820,
        bg_bottom_color: 24'h000000,
        split_row:       5'd19,
        sun_color:       24'hF0F0F0,
        sun_sky_color:   24'h000820,
        moon_sky_color:  24'h000008,
        layer_enable:    2'd0
    };

    // stage load enables handed from the top to every datapath unit
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_pipe_ctl;

    typedef enum logic [1:0] {BG_BLACK, BG_TOP, BG_BOTTOM, BG_GRAD} t_bg_kind;

    // ceil(256 * sqrt(d2)), elaboration only
    function automatic logic [31:0] ceil_root256(input logic [31:0] d2);
        logic [31:0] v;
        logic [31:0] r;
        logic [31:0] t;
        v = d2 << 16;
        r = '0;
        for (int b = 15; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if (t * t <= v) begin
                r = t;
            end
        end
        if (r * r < v) begin
            r = r + 32'd1;
        end
        return r;
    endfunction

    // gradient: floor(q / span) by reciprocal, q below 2^14, span below 32
    localparam int GRAD_Q_W   = 14;
    localparam int RECIP_SH   = 19;
    localparam int RECIP_W    = 20;
    localparam int RECIP_N    = 2 ** SPLIT_W;
    typedef logic [RECIP_N-1:0][RECIP_W-1:0] t_recip_tbl;

    function automatic t_recip_tbl build_recip_tbl();
        t_recip_tbl  tbl;
        logic [31:0] num;
        logic [31:0] rem;
        logic [31:0] quo;
        tbl = '0;
        for (int s = 1; s < RECIP_N; s++) begin
            // ceil(2^RECIP_SH / s) by shift and subtract
            num = 32'((2 ** RECIP_SH) + s - 1);
            rem = '0;
            quo = '0;
            for (int b = 31; b >= 0; b--) begin
                rem = {rem[30:0], num[b]};
                if (rem >= 32'(s)) begin
                    rem    = rem - 32'(s);
                    quo[b] = 1'b1;
                end
            end
            tbl[s] = RECIP_W'(quo);
        end
        return tbl;
    endfunction

    localparam t_recip_tbl RECIP_TBL = build_recip_tbl();

    // sun fade, indexed by squared distance past the disc edge
    localparam int SUN_R2        = SUN_RADIUS * SUN_RADIUS;
    localparam int SUN_G2        = SUN_GLOW_RADIUS * SUN_GLOW_RADIUS;
    localparam bit SUN_HAS_GLOW  = SUN_GLOW_RADIUS > SUN_RADIUS;
    localparam int SUN_GLOW_SPAN = SUN_HAS_GLOW ? SUN_GLOW_RADIUS - SUN_RADIUS : 1;
    localparam int SUN_TBL_N     = SUN_HAS_GLOW ? SUN_G2 - SUN_R2 : 1;
    localparam int SUN_IDX_W     = (SUN_TBL_N > 1) ? $clog2(SUN_TBL_N) : 1;
    localparam int FADE_W        = 9;
    localparam int D2_W          = 19;
    typedef logic [SUN_TBL_N-1:0][FADE_W-1:0] t_sun_tbl;

    function automatic t_sun_tbl build_sun_tbl();
        t_sun_tbl    tbl;
        logic [31:0] a;
        logic [31:0] f;
        tbl = '0;
        if (SUN_HAS_GLOW) begin
            for (int i = 0; i < SUN_TBL_N; i++) begin
                a = ceil_root256(32'(SUN_R2 + 1 + i));
                f = (32'(256 * SUN_GLOW_RADIUS) - a) / SUN_GLOW_SPAN;
                if (f > 32'd256) begin
                    f = 32'd256;
                end
                tbl[i] = FADE_W'(f);
            end
        end
        return tbl;
    endfunction

    localparam t_sun_tbl SUN_FADE_TBL = build_sun_tbl();

    // moon: disc radius 3, glow radius 5, center column 3, row ZONE_TOP+3
    localparam int MOON_CX     = 3;
    localparam int MOON_CY     = ZONE_TOP + 3;
    localparam int MOON_R2     = 9;
    localparam int MOON_G2     = 25;
    localparam int MOON_REACH  = 5;
    localparam int MOON_SPAN   = 2 * MOON_REACH + 1;
    localparam int MOON_N      = MOON_SPAN * MOON_SPAN;
    localparam int MOON_IDX_W  = $clog2(MOON_N);
    localparam int MOON_SHADE_BASE = 160;
    localparam int MOON_SHADE_MOD  = 40;
    localparam int MOON_SHADE_DARK = 120;
    localparam int MOON_SHADE_MIN  = 80;
    localparam int MOON_SHADE_MAX  = 220;
    localparam int MOON_BLUE_NUM   = 85;
    localparam int MOON_BLUE_DEN   = 100;
    localparam int MOON_GLOW_FULL  = 1280;

    // glow blend: red/green weight 0.4 over 1280, blue weight 0.3 over 2560
    localparam int MOON_RG_GAIN = 400;
    localparam int MOON_RG_DEN  = 1280;
    localparam int MOON_B_GAIN  = 480;
    localparam int MOON_B_DEN   = 2560;
    localparam int MOON_N_W     = 20;
    localparam int DIV5_MUL     = 52429;
    localparam int DIV5_SH      = 18;

    typedef enum logic [1:0] {MOON_NONE, MOON_DISC, MOON_GLOW} t_moon_kind;

    typedef struct packed {
        t_moon_kind      kind;
        logic [CH_W-1:0] shade;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] fade;
    } t_moon_ent;

    typedef t_moon_ent [MOON_N-1:0] t_moon_tbl;

    function automatic t_moon_tbl build_moon_tbl();
        t_moon_tbl   tbl;
        t_moon_ent   e;
        int          dx;
        int          dy;
        int          d2;
        int          shade;
        logic [31:0] a;
        tbl = '0;
        for (int ix = 0; ix < MOON_SPAN; ix++) begin
            for (int iy = 0; iy < MOON_SPAN; iy++) begin
                dx = ix - MOON_REACH;
                dy = iy - MOON_REACH;
                d2 = dx * dx + dy * dy;
                e = '0;
                e.kind = MOON_NONE;
                if (d2 <= MOON_R2) begin
                    shade = MOON_SHADE_BASE + ((dx * 13 + dy * 7) % MOON_SHADE_MOD);
                    if ((dx == -1 && dy == -1) || (dx == 1 && dy == 1)) begin
                        shade = MOON_SHADE_DARK;
                    end
                    if (shade < MOON_SHADE_MIN) begin
                        shade = MOON_SHADE_MIN;
                    end
                    if (shade > MOON_SHADE_MAX) begin
                        shade = MOON_SHADE_MAX;
                    end
                    e.kind  = MOON_DISC;
                    e.shade = CH_W'(shade);
                    e.blue  = CH_W'(shade * MOON_BLUE_NUM / MOON_BLUE_DEN);
                end else if (d2 <= MOON_G2) begin
                    a = ceil_root256(32'(d2));
                    e.kind = MOON_GLOW;
                    e.fade = CH_W'((32'(MOON_GLOW_FULL) - a) / 2);
                end
                tbl[ix * MOON_SPAN + iy] = e;
            end
        end
        return tbl;
    endfunction

    localparam t_moon_tbl MOON_TBL = build_moon_tbl();

endpackage

// File: src/spc_background.sv
// background layer: black, solid or row gradient, three pipeline stages
`timescale 1ns / 1ps

module spc_background (
    input  logic                    i_clk,
    input  spc_pkg::t_pipe_ctl      i_ctl,
    input  spc_pkg::t_cfg           i_cfg,
    input  logic [spc_pkg::Y_W-1:0] i_pixel_y,
    output spc_pkg::t_pix           o_pix
);

    localparam int SW = spc_pkg::SPLIT_W;
    localparam int QW = spc_pkg::GRAD_Q_W;
    localparam int RW = spc_pkg::RECIP_W;

    // stage 1: row classification
    logic signed [6:0]   y_s;
    logic signed [6:0]   split_s;
    logic signed [6:0]   rise_span;
    logic signed [6:0]   set_span;
    spc_pkg::t_bg_kind   n_kind1;
    logic [SW-1:0]       n_num1;
    logic [SW-1:0]       n_span1;
    spc_pkg::t_bg_kind   r_kind1;
    logic [SW-1:0]       r_num1;
    logic [SW-1:0]       r_span1;

    always_comb begin
        y_s       = $signed({2'b00, i_pixel_y});
        split_s   = $signed({2'b00, i_cfg.split_row});
        rise_span = split_s - 7'(spc_pkg::ZONE_TOP);
        set_span  = 7'(spc_pkg::ZONE_BOTTOM) - split_s;
        n_kind1   = spc_pkg::BG_BLACK;
        n_num1    = '0;
        n_span1   = '0;
        case (i_cfg.bg_mode)
            spc_pkg::MODE_BLACK: begin
                n_kind1 = spc_pkg::BG_BLACK;
            end
            spc_pkg::MODE_SOLID: begin
                n_kind1 = spc_pkg::BG_TOP;
            end
            spc_pkg::MODE_SUNRISE: begin
                n_num1  = SW'(y_s - 7'(spc_pkg::ZONE_TOP));
                n_span1 = SW'(rise_span);
                if (y_s <= split_s && rise_span > 7'sd0) begin
                    n_kind1 = spc_pkg::BG_GRAD;
                end else begin
                    n_kind1 = spc_pkg::BG_BOTTOM;
                end
            end
            spc_pkg::MODE_SUNSET: begin
                n_num1  = SW'(y_s - split_s);
                n_span1 = SW'(set_span);
                if (y_s < split_s) begin
                    n_kind1 = spc_pkg::BG_TOP;
                end else if (set_span > 7'sd0) begin
                    n_kind1 = spc_pkg::BG_GRAD;
                end else begin
                    n_kind1 = spc_pkg::BG_BOTTOM;
                end
            end
            default: begin
                n_kind1 = spc_pkg::BG_BLACK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_kind1 <= n_kind1;
            r_num1  <= n_num1;
            r_span1 <= n_span1;
        end
    end

    // stage 2: offset numerator (bot-top)*num + 256*span, never negative
    logic signed [8:0]    diff    [3];
    logic signed [14:0]   prod    [3];
    logic signed [15:0]   qsum    [3];
    logic [QW-1:0]        n_q2    [3];
    logic [QW-1:0]        r_q2    [3];
    logic [RW-1:0]        r_recip2;
    spc_pkg::t_bg_kind    r_kind2;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            diff[c] = $signed({1'b0, i_cfg.bg_bottom_color[c]})
                    - $signed({1'b0, i_cfg.bg_top_color[c]});
            prod[c] = diff[c] * $signed({1'b0, r_num1});
            qsum[c] = 16'(prod[c]) + $signed({3'b000, r_span1, 8'h00});
            n_q2[c] = qsum[c][QW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_q2     <= n_q2;
            r_recip2 <= spc_pkg::RECIP_TBL[r_span1];
            r_kind2  <= r_kind1;
        end
    end

    // stage 3: quotient by reciprocal, then top + q - 256
    logic [QW+RW-1:0]    mult   [3];
    logic [9:0]          gval   [3];
    spc_pkg::t_pix       n_pix3;
    spc_pkg::t_pix       r_pix3;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            mult[c] = (QW+RW)'(r_q2[c]) * (QW+RW)'(r_recip2);
            gval[c] = {2'b00, i_cfg.bg_top_color[c]}
                    + {1'b0, mult[c][spc_pkg::RECIP_SH +: 9]} - 10'd256;
            case (r_kind2)
                spc_pkg::BG_BLACK:  n_pix3[c] = '0;
                spc_pkg::BG_TOP:    n_pix3[c] = i_cfg.bg_top_color[c];
                spc_pkg::BG_BOTTOM: n_pix3[c] = i_cfg.bg_bottom_color[c];
                spc_pkg::BG_GRAD:   n_pix3[c] = gval[c][7:0];
                default:            n_pix3[c] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_pix3 <= n_pix3;
        end
    end

    assign o_pix = r_pix3;

endmodule

// File: src/spc_sun.sv
// sun layer: disc and faded glow around the top right corner
`timescale 1ns / 1ps

module spc_sun (
    input  logic                    i_clk,
    input  spc_pkg::t_pipe_ctl      i_ctl,
    input  spc_pkg::t_cfg           i_cfg,
    input  logic [spc_pkg::X_W-1:0] i_pixel_x,
    input  logic [spc_pkg::Y_W-1:0] i_pixel_y,
    output spc_pkg::t_pix           o_pix,
    output logic                    o_hit
);

    localparam int DW = spc_pkg::D2_W;
    localparam int FW = spc_pkg::FADE_W;

    // stage 1: squared distance to the sun center
    logic signed [9:0]  dx;
    logic signed [9:0]  dy;
    logic signed [19:0] sqx;
    logic signed [19:0] sqy;
    logic [DW-1:0]      n_d2;
    logic [DW-1:0]      r_d2;

    always_comb begin
        dx   = 10'(spc_pkg::PANEL_WIDTH - 1) - $signed({4'b0000, i_pixel_x});
        dy   = $signed({5'b00000, i_pixel_y}) - 10'(spc_pkg::ZONE_TOP);
        sqx  = dx * dx;
        sqy  = dy * dy;
        n_d2 = {1'b0, sqx[DW-2:0]} + {1'b0, sqy[DW-2:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_d2 <= n_d2;
        end
    end

    // stage 2: region and fade lookup
    logic                         n_disc2;
    logic                         n_glow2;
    logic [DW-1:0]                fade_off;
    logic [FW-1:0]                n_fade2;
    logic                         r_disc2;
    logic                         r_glow2;
    logic [FW-1:0]                r_fade2;

    always_comb begin
        n_disc2  = r_d2 <= DW'(spc_pkg::SUN_R2);
        n_glow2  = !n_disc2 && spc_pkg::SUN_HAS_GLOW && (r_d2 <= DW'(spc_pkg::SUN_G2));
        fade_off = r_d2 - DW'(spc_pkg::SUN_R2 + 1);
        n_fade2  = n_glow2 ? spc_pkg::SUN_FADE_TBL[fade_off[spc_pkg::SUN_IDX_W-1:0]] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_disc2 <= n_disc2;
            r_glow2 <= n_glow2;
            r_fade2 <= n_fade2;
        end
    end

    // stage 3: blend sun and sky by the fade
    logic [FW-1:0]   inv_fade;
    logic [16:0]     blend   [3];
    spc_pkg::t_pix   n_pix3;
    spc_pkg::t_pix   r_pix3;
    logic            r_hit3;

    always_comb begin
        inv_fade = FW'(256) - r_fade2;
        for (int c = 0; c < 3; c++) begin
            blend[c] = 17'(i_cfg.sun_color[c]) * 17'(r_fade2)
                     + 17'(i_cfg.sun_sky_color[c]) * 17'(inv_fade);
            n_pix3[c] = r_disc2 ? i_cfg.sun_color[c] : blend[c][15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_pix3 <= n_pix3;
            r_hit3 <= r_disc2 || r_glow2;
        end
    end

    assign o_pix = r_pix3;
    assign o_hit = r_hit3;

endmodule

// File: src/spc_moon.sv
// moon layer: mottled disc from a table and a glow blended into the sky
`timescale 1ns / 1ps

module spc_moon (
    input  logic                    i_clk,
    input  spc_pkg::t_pipe_ctl      i_ctl,
    input  spc_pkg::t_cfg           i_cfg,
    input  logic [spc_pkg::X_W-1:0] i_pixel_x,
    input  logic [spc_pkg::Y_W-1:0] i_pixel_y,
    output spc_pkg::t_pix           o_pix,
    output logic                    o_hit
);

    localparam int IW = spc_pkg::MOON_IDX_W;
    localparam int NW = spc_pkg::MOON_N_W;

    // stage 1: window around the moon and table lookup
    logic signed [7:0]  ix;
    logic signed [7:0]  iy;
    logic               in_win;
    logic [IW-1:0]      idx;
    spc_pkg::t_moon_ent n_ent1;
    spc_pkg::t_moon_ent r_ent1;

    always_comb begin
        ix     = $signed({2'b00, i_pixel_x})
               - 8'(spc_pkg::MOON_CX - spc_pkg::MOON_REACH);
        iy     = $signed({3'b000, i_pixel_y})
               - 8'(spc_pkg::MOON_CY - spc_pkg::MOON_REACH);
        in_win = (ix >= 8'sd0) && (ix < 8'(spc_pkg::MOON_SPAN))
              && (iy >= 8'sd0) && (iy < 8'(spc_pkg::MOON_SPAN));
        idx    = IW'(ix[3:0]) * IW'(spc_pkg::MOON_SPAN) + IW'(iy[3:0]);
        n_ent1 = '0;
        if (in_win) begin
            n_ent1 = spc_pkg::MOON_TBL[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_ent1 <= n_ent1;
        end
    end

    // stage 2: glow numerators
    logic [10:0]        w_rg;
    logic [11:0]        w_b;
    logic [NW-1:0]      n_num_r;
    logic [NW-1:0]      n_num_g;
    logic [NW-1:0]      n_num_b;
    logic [NW-1:0]      r_num_r;
    logic [NW-1:0]      r_num_g;
    logic [NW-1:0]      r_num_b;
    spc_pkg::t_moon_ent r_ent2;

    always_comb begin
        w_rg    = 11'(spc_pkg::MOON_RG_DEN) - {2'b00, r_ent1.fade, 1'b0};
        w_b     = 12'(spc_pkg::MOON_B_DEN) - 12'(3 * r_ent1.fade);
        n_num_r = NW'(spc_pkg::MOON_RG_GAIN) * NW'(r_ent1.fade)
                + NW'(i_cfg.moon_sky_color[spc_pkg::CH_RED]) * NW'(w_rg);
        n_num_g = NW'(spc_pkg::MOON_RG_GAIN) * NW'(r_ent1.fade)
                + NW'(i_cfg.moon_sky_color[spc_pkg::CH_GREEN]) * NW'(w_rg);
        n_num_b = NW'(spc_pkg::MOON_B_GAIN) * NW'(r_ent1.fade)
                + NW'(i_cfg.moon_sky_color[spc_pkg::CH_BLUE]) * NW'(w_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_num_r <= n_num_r;
            r_num_g <= n_num_g;
            r_num_b <= n_num_b;
            r_ent2  <= r_ent1;
        end
    end

    // stage 3: divide by 1280 and 2560 as a shift then a divide by five
    logic [26:0]   q_r;
    logic [26:0]   q_g;
    logic [26:0]   q_b;
    spc_pkg::t_pix n_pix3;
    spc_pkg::t_pix r_pix3;
    logic          r_hit3;

    always_comb begin
        q_r = 27'(r_num_r[18:8]) * 27'(spc_pkg::DIV5_MUL);
        q_g = 27'(r_num_g[18:8]) * 27'(spc_pkg::DIV5_MUL);
        q_b = 27'(r_num_b[19:9]) * 27'(spc_pkg::DIV5_MUL);
        if (r_ent2.kind == spc_pkg::MOON_DISC) begin
            n_pix3[spc_pkg::CH_RED]   = r_ent2.shade;
            n_pix3[spc_pkg::CH_GREEN] = r_ent2.shade;
            n_pix3[spc_pkg::CH_BLUE]  = r_ent2.blue;
        end else begin
            n_pix3[spc_pkg::CH_RED]   = q_r[spc_pkg::DIV5_SH +: spc_pkg::CH_W];
            n_pix3[spc_pkg::CH_GREEN] = q_g[spc_pkg::DIV5_SH +: spc_pkg::CH_W];
            n_pix3[spc_pkg::CH_BLUE]  = q_b[spc_pkg::DIV5_SH +: spc_pkg::CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_pix3 <= n_pix3;
            r_hit3 <= r_ent2.kind != spc_pkg::MOON_NONE;
        end
    end

    assign o_pix = r_pix3;
    assign o_hit = r_hit3;

endmodule

// File: src/sky_pixel_compositor_core.sv
// Sky pixel compositor: one panel pixel in, one sky color out. The layers are
// a background (black, solid, sunrise or sunset gradient), then the sun, then
// the moon, computed side by side in three register stages followed by an
// output register; a new pixel is taken every clock unless the output stalls.
// Multiplies stay narrow, with one level of them per stage; fades come from
// constant tables indexed by squared distance or position. A stalled output
// holds the pipeline only once every stage is full; bubbles are squeezed out.
// Configuration writes take effect at once; the user must make them while no
// pixel is in flight, as the block itself does not enforce this.
`timescale 1ns / 1ps
`include "sky_pixel_compositor_core_macros.svh"

module sky_pixel_compositor_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [spc_pkg::X_W-1:0]       i_pixel_x,
    input  logic [spc_pkg::Y_W-1:0]       i_pixel_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [spc_pkg::CH_W-1:0]      o_red,
    output logic [spc_pkg::CH_W-1:0]      o_green,
    output logic [spc_pkg::CH_W-1:0]      o_blue,
    output logic                          o_covered,
    input  logic                          i_cfg_we,
    input  logic [spc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [spc_pkg::CFG_W-1:0]     i_cfg_data
);

    // configuration registers
    spc_pkg::t_cfg r_cfg;
    spc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                spc_pkg::CFG_BG_MODE:         n_cfg.bg_mode         = i_cfg_data[1:0];
                spc_pkg::CFG_BG_TOP_COLOR:    n_cfg.bg_top_color    = i_cfg_data;
                spc_pkg::CFG_BG_BOTTOM_COLOR: n_cfg.bg_bottom_color = i_cfg_data;
                spc_pkg::CFG_SPLIT_ROW:
                    n_cfg.split_row = i_cfg_data[spc_pkg::SPLIT_W-1:0];
                spc_pkg::CFG_SUN_COLOR:       n_cfg.sun_color       = i_cfg_data;
                spc_pkg::CFG_SUN_SKY_COLOR:   n_cfg.sun_sky_color   = i_cfg_data;
                spc_pkg::CFG_MOON_SKY_COLOR:  n_cfg.moon_sky_color  = i_cfg_data;
                spc_pkg::CFG_LAYER_ENABLE:    n_cfg.layer_enable    = i_cfg_data[1:0];
                default:                      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= spc_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // valid chain; a stage loads when empty or when the next one moves
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               r_out_valid;
    logic               en4;
    spc_pkg::t_pipe_ctl ctl;

    always_comb begin
        en4     = !r_out_valid || !i_out_stall;
        ctl.en3 = !r_v3 || en4;
        ctl.en2 = !r_v2 || ctl.en3;
        ctl.en1 = !r_v1 || ctl.en2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ctl.en1) begin
                r_v1 <= i_in_valid;
            end
            if (ctl.en2) begin
                r_v2 <= r_v1;
            end
            if (ctl.en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_out_valid <= r_v3;
            end
        end
    end

    // zone check travels beside the layer units
    logic n_cov1;
    logic r_cov1;
    logic r_cov2;
    logic r_cov3;

    assign n_cov1 = ({4'b0000, i_pixel_y} >= 9'(spc_pkg::ZONE_TOP))
                 && ({4'b0000, i_pixel_y} <= 9'(spc_pkg::ZONE_BOTTOM))
                 && ({3'b000, i_pixel_x} < 9'(spc_pkg::PANEL_WIDTH));

    always_ff @(posedge i_clk) begin
        if (ctl.en1) begin
            r_cov1 <= n_cov1;
        end
        if (ctl.en2) begin
            r_cov2 <= r_cov1;
        end
        if (ctl.en3) begin
            r_cov3 <= r_cov2;
        end
    end

    spc_pkg::t_pix bg_pix;
    spc_pkg::t_pix sun_pix;
    spc_pkg::t_pix moon_pix;
    logic          sun_hit;
    logic          moon_hit;

    spc_background u_background (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_cfg     (r_cfg),
        .i_pixel_y (i_pixel_y),
        .o_pix     (bg_pix)
    );

    spc_sun u_sun (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_cfg     (r_cfg),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .o_pix     (sun_pix),
        .o_hit     (sun_hit)
    );

    spc_moon u_moon (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_cfg     (r_cfg),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .o_pix     (moon_pix),
        .o_hit     (moon_hit)
    );

    // layer order: moon over sun over background
    spc_pkg::t_pix n_out_pix;
    spc_pkg::t_pix r_out_pix;
    logic          r_out_cov;

    always_comb begin
        n_out_pix = '0;
        if (r_cov3) begin
            if (moon_hit && r_cfg.layer_enable[spc_pkg::LAYER_MOON]) begin
                n_out_pix = moon_pix;
            end else if (sun_hit && r_cfg.layer_enable[spc_pkg::LAYER_SUN]) begin
                n_out_pix = sun_pix;
            end else begin
                n_out_pix = bg_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_out_pix <= n_out_pix;
            r_out_cov <= r_cov3;
        end
    end

    assign o_in_stall  = !ctl.en1;
    assign o_out_valid = r_out_valid;
    assign o_red       = r_out_pix[spc_pkg::CH_RED];
    assign o_green     = r_out_pix[spc_pkg::CH_GREEN];
    assign o_blue      = r_out_pix[spc_pkg::CH_BLUE];
    assign o_covered   = r_out_cov;

    `SPC_ASSERT_NEXT(a_accept_loads_stage1, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_v1, "accepted transfer did not reach stage one")
    `SPC_ASSERT_NEXT(a_stage3_reaches_out, i_clk, i_rst_n, r_v3 && en4, r_out_valid, "stage three item lost before the output")
    `SPC_ASSERT_SAME(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, r_out_valid && i_out_stall && r_v1 && r_v2 && r_v3, "input stalled with room in the pipeline")
    `SPC_ASSERT_SAME(a_uncovered_is_black, i_clk, i_rst_n, r_out_valid && !r_out_cov, (o_red == 8'd0) && (o_green == 8'd0) && (o_blue == 8'd0), "pixel outside the zone is not black")

endmodule
